[hdl/bbr_pkg.sv]
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies; used by bbr_avg and box_blur_3x3_rgb.
`default_nettype none

package bbr_pkg;

  localparam int CHAN_W       = 8;
  localparam int SUM_W        = 12;   // nine 8-bit values plus rounding half
  localparam int CNT_W        = 4;    // neighbor count, 1..9
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // [row][col], row 0 = top, col 0 = left
  typedef pixel_t [2:0][2:0] window_t;

  // one line buffer entry: two rows of the same column
  typedef struct packed {
    pixel_t above;
    pixel_t current;
  } line_t;

  // which neighbors lie inside the image
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } mask_t;

endpackage

`default_nettype wire

[hdl/bbr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bbr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/bbr_avg.sv]
// Masked 3x3 sum and rounded mean per channel (reciprocal multiply).
// Depends on bbr_pkg.
`default_nettype none

module bbr_avg (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire bbr_pkg::window_t win_i,
  input  wire bbr_pkg::mask_t   mask_i,
  output bbr_pkg::pixel_t       avg_o
);

  localparam int RecipW = 17;
  localparam int Shift  = 16;
  localparam int ProdW  = bbr_pkg::SUM_W + RecipW;

  // ceil(2^16 / n); exact floor division for any 12-bit numerator
  function automatic logic [RecipW-1:0] recip(input logic [bbr_pkg::CNT_W-1:0] cnt);
    logic [RecipW-1:0] r;
    unique case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [2:0]                  row_en, col_en;
  logic [1:0]                  n_rows, n_cols;
  logic [bbr_pkg::CNT_W-1:0]   cnt;
  logic [bbr_pkg::SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [bbr_pkg::SUM_W-1:0]   num_r_q, num_g_q, num_b_q;
  logic [RecipW-1:0]           recip_q;
  logic [ProdW-1:0]            prod_r, prod_g, prod_b;

  always_comb begin
    row_en = {mask_i.bottom, 1'b1, mask_i.top};
    col_en = {mask_i.right, 1'b1, mask_i.left};
    n_rows = 2'd1 + 2'(mask_i.top) + 2'(mask_i.bottom);
    n_cols = 2'd1 + 2'(mask_i.left) + 2'(mask_i.right);
    cnt    = bbr_pkg::CNT_W'(n_rows) * bbr_pkg::CNT_W'(n_cols);
    sum_r  = '0;
    sum_g  = '0;
    sum_b  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_en[r] && col_en[c]) begin
          sum_r = sum_r + bbr_pkg::SUM_W'(win_i[r][c].red);
          sum_g = sum_g + bbr_pkg::SUM_W'(win_i[r][c].green);
          sum_b = sum_b + bbr_pkg::SUM_W'(win_i[r][c].blue);
        end
      end
    end
  end

  // numerator already carries the half-up rounding term
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_r_q <= sum_r + bbr_pkg::SUM_W'(cnt >> 1);
      num_g_q <= sum_g + bbr_pkg::SUM_W'(cnt >> 1);
      num_b_q <= sum_b + bbr_pkg::SUM_W'(cnt >> 1);
      recip_q <= recip(cnt);
    end
  end

  assign prod_r = ProdW'(num_r_q) * ProdW'(recip_q);
  assign prod_g = ProdW'(num_g_q) * ProdW'(recip_q);
  assign prod_b = ProdW'(num_b_q) * ProdW'(recip_q);

  assign avg_o.red   = prod_r[Shift +: bbr_pkg::CHAN_W];
  assign avg_o.green = prod_g[Shift +: bbr_pkg::CHAN_W];
  assign avg_o.blue  = prod_b[Shift +: bbr_pkg::CHAN_W];

endmodule

`default_nettype wire

[hdl/box_blur_3x3_rgb.sv]
// 3x3 RGB box blur over a raster stream, border-aware rounded mean.
// Each accepted request: line RAM read at accept, window update plus write-back
// (S_RD), sum (S_SUM), reciprocal multiply (S_DIV) into the output register; one
// without a result returns to idle after S_RD, and ignored drain requests leave it idle.
// in_stall_o holds off new requests while busy. Output stalls hold the block in its last step.
// Reset clears control, counters and window; line RAM contents stay undefined.
// Depends on bbr_pkg, bbr_ram, bbr_avg.
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bbr_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             mode_i,
  input  wire logic [bbr_pkg::CHAN_W-1:0]       in_red_i,
  input  wire logic [bbr_pkg::CHAN_W-1:0]       in_green_i,
  input  wire logic [bbr_pkg::CHAN_W-1:0]       in_blue_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [bbr_pkg::CHAN_W-1:0]            out_red_o,
  output logic [bbr_pkg::CHAN_W-1:0]            out_green_o,
  output logic [bbr_pkg::CHAN_W-1:0]            out_blue_o,
  output logic                                  frame_last_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WExtW = ($clog2(MAX_WIDTH + 1) > bbr_pkg::IMG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : bbr_pkg::IMG_WIDTH_W;
  localparam int RowW  = $clog2(MAX_HEIGHT + 3);   // input row runs to height+1
  localparam int HExtW = (RowW > bbr_pkg::IMG_HEIGHT_W) ? RowW : bbr_pkg::IMG_HEIGHT_W;
  localparam int LineW = $bits(bbr_pkg::line_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [bbr_pkg::IMG_WIDTH_W-1:0]  img_width_q;
  logic [bbr_pkg::IMG_HEIGHT_W-1:0] img_height_q;
  logic [WExtW-1:0]                 w_raw, w_eff;
  logic [HExtW-1:0]                 h_raw, h_eff;

  logic [1:0]      state_q, state_d;
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [WExtW-1:0] in_col_nxt, out_col_nxt;
  logic [RowW-1:0]  in_row_nxt, out_row_nxt;

  logic done, take, emit, last;
  bbr_pkg::mask_t   mask, mask_q;
  logic             last_q;
  bbr_pkg::pixel_t  px_q;
  bbr_pkg::window_t win_q;
  bbr_pkg::line_t   ram_rdata, ram_wdata;
  logic [LineW-1:0] ram_rdata_raw;
  logic             ram_we;
  bbr_pkg::pixel_t  avg;
  logic             out_load;

  logic             out_valid_q;
  bbr_pkg::pixel_t  out_pix_q;
  logic             out_last_q;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= bbr_pkg::IMG_WIDTH_RST;
      img_height_q <= bbr_pkg::IMG_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bbr_pkg::CFG_IMAGE_WIDTH:  img_width_q  <= cfg_data_i[bbr_pkg::IMG_WIDTH_W-1:0];
        bbr_pkg::CFG_IMAGE_HEIGHT: img_height_q <= cfg_data_i;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    w_raw = WExtW'(img_width_q);
    h_raw = HExtW'(img_height_q);
    if (w_raw == '0) begin
      w_eff = WExtW'(1);
    end else if (w_raw > WExtW'(MAX_WIDTH)) begin
      w_eff = WExtW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = HExtW'(1);
    end else if (h_raw > HExtW'(MAX_HEIGHT)) begin
      h_eff = HExtW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // ---- control ----
  assign in_stall_o = (state_q != S_IDLE);
  assign done       = HExtW'(in_row_q) >= h_eff;
  // drain during a frame is dropped; any request after frame end acts as drain
  assign take       = in_valid_i && !in_stall_o && !(mode_i && !done);

  assign in_col_nxt  = WExtW'(in_col_q) + WExtW'(1);
  assign in_row_nxt  = in_row_q + RowW'(1);
  assign out_col_nxt = WExtW'(out_col_q) + WExtW'(1);
  assign out_row_nxt = out_row_q + RowW'(1);

  assign emit = (in_row_q >= RowW'(2)) || ((in_row_q == RowW'(1)) && (in_col_q != '0));

  always_comb begin
    mask.top    = (out_row_q != '0);
    mask.bottom = HExtW'(out_row_nxt) < h_eff;
    mask.left   = (out_col_q != '0);
    mask.right  = out_col_nxt < w_eff;
  end
  assign last = !mask.bottom && !mask.right;

  assign out_load = (state_q == S_DIV) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) state_d = S_RD;
      end
      S_RD: begin
        if (in_col_nxt >= w_eff) begin
          in_col_d = '0;
          in_row_d = in_row_nxt;
        end else begin
          in_col_d = in_col_nxt[ColW-1:0];
        end
        if (emit) begin
          state_d = S_SUM;
          if (last) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
          end else if (out_col_nxt >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_nxt;
          end else begin
            out_col_d = out_col_nxt[ColW-1:0];
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: state_d = S_DIV;
      S_DIV: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // register write restarts the frame
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      px_q.red   <= done ? '0 : in_red_i;
      px_q.green <= done ? '0 : in_green_i;
      px_q.blue  <= done ? '0 : in_blue_i;
    end
    if (state_q == S_RD) begin
      mask_q <= mask;
      last_q <= last;
    end
  end

  // ---- line buffers: one entry holds both earlier rows of a column ----
  // Read at accept, write-back in S_RD; the FSM keeps the next read behind it.
  assign ram_we    = (state_q == S_RD);
  assign ram_rdata = bbr_pkg::line_t'(ram_rdata_raw);
  assign ram_wdata.above   = ram_rdata.current;
  assign ram_wdata.current = px_q;

  bbr_ram #(
    .WIDTH (LineW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i (ram_wdata),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata_raw)
  );

  // ---- 3x3 window ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_we_i || ((state_q == S_SUM) && last_q)) begin
      win_q <= '0;
    end else if (state_q == S_RD) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= ram_rdata.above;
      win_q[1][2] <= ram_rdata.current;
      win_q[2][2] <= px_q;
    end
  end

  bbr_avg u_avg (
    .clk_i  (clk_i),
    .load_i (state_q == S_SUM),
    .win_i  (win_q),
    .mask_i (mask_q),
    .avg_o  (avg)
  );

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= avg;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_pix_q.red;
  assign out_green_o  = out_pix_q.green;
  assign out_blue_o   = out_pix_q.blue;
  assign frame_last_o = out_last_q;

  // ---- assertions ----
  a_out_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DIV)
    else $error("output became valid without a finished average");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WExtW'(in_col_q) < w_eff)
    else $error("input column beyond image width");

  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= in_row_q)
    else $error("output row ahead of input row");

endmodule

`default_nettype wire
